// File: sv/pale_pkg.sv
// Package for the positional array list engine: field widths, request and
// status codes, controller states, datapath commands and the control structs.
// No dependencies; every other file imports it.
`default_nettype none

package pale_pkg;

  localparam int unsigned CAPACITY_DEF  = 128;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned FUNC_BITS   = 3;
  localparam int unsigned POS_BITS    = 8;
  localparam int unsigned ITEM_BITS   = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 8;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_INSERT  = 3'd0,
    FN_DELETE  = 3'd1,
    FN_REVERSE = 3'd2,
    FN_SORTED  = 3'd3,
    FN_READ    = 3'd4
  } func_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UP,
    S_PLACE,
    S_GRAB,
    S_DOWN,
    S_SHRINK,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_POS_INIT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_UP,
    OP_PLACE,
    OP_RD_ISSUE,
    OP_GRAB,
    OP_DOWN,
    OP_DEC,
    OP_REV_INIT,
    OP_REV_RD,
    OP_REV_W1,
    OP_REV_W2,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 ins_pos_bad;
    logic                 acc_pos_bad;
    logic                 full;
    logic                 len_le1;
    logic                 scan_end;
    logic                 up_more;
    logic                 down_more;
    logic                 rev_more;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/pale_ifs.sv
// Request and response channel interfaces of the positional array list engine.
// Depends on pale_pkg for the field widths.
`default_nettype none

interface pale_req_if;
  import pale_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [FUNC_BITS-1:0]        func;
  logic [POS_BITS-1:0]         position;
  logic signed [ITEM_BITS-1:0] item_value;
  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface pale_rsp_if;
  import pale_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [STATUS_BITS-1:0]      status;
  logic signed [ITEM_BITS-1:0] read_value;
  logic [COUNT_BITS-1:0]       count_after;
  modport source (output valid, status, read_value, count_after, input ready);
  modport sink   (input valid, status, read_value, count_after, output ready);
endinterface

`default_nettype wire

// File: sv/pale_ctrl.sv
// Controller state machine of the positional array list engine.
// Depends on pale_pkg; drives cmd_t to pale_dp and reads stat_t back.
`default_nettype none

module pale_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pale_pkg::cmd_t       cmd,
  input  wire pale_pkg::stat_t stat
);
  import pale_pkg::*;

  state_t  state, state_next;
  status_t res, res_next;
  logic    out_valid_next;
  logic    out_free;

  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        res_next   = ST_OK;
        state_next = S_FINISH;
        case (stat.func)
          FN_INSERT: begin
            if (stat.ins_pos_bad) res_next = ST_BAD_POS;
            else if (stat.full) res_next = ST_FULL;
            else state_next = S_UP;
          end
          FN_DELETE: begin
            if (stat.acc_pos_bad) res_next = ST_BAD_POS;
            else state_next = S_GRAB;
          end
          FN_READ: begin
            if (stat.acc_pos_bad) res_next = ST_BAD_POS;
            else state_next = S_GRAB;
          end
          FN_REVERSE: begin
            if (!stat.len_le1) state_next = S_REV_RD;
          end
          FN_SORTED: begin
            if (stat.full) res_next = ST_FULL;
            else state_next = S_SCAN;
          end
          default: res_next = ST_OK;
        endcase
      end
      S_SCAN:   if (stat.scan_end) state_next = S_UP;
      S_UP:     if (!stat.up_more) state_next = S_PLACE;
      S_PLACE:  state_next = S_FINISH;
      S_GRAB: begin
        if (stat.func == FN_DELETE) state_next = S_DOWN;
        else state_next = S_FINISH;
      end
      S_DOWN:   if (!stat.down_more) state_next = S_SHRINK;
      S_SHRINK: state_next = S_FINISH;
      S_REV_RD: begin
        if (stat.rev_more) state_next = S_REV_W1;
        else state_next = S_FINISH;
      end
      S_REV_W1: state_next = S_REV_W2;
      S_REV_W2: state_next = S_REV_RD;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.res  = res;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DECODE: begin
        case (stat.func)
          FN_INSERT:  cmd.op = OP_POS_INIT;
          FN_DELETE:  cmd.op = OP_RD_ISSUE;
          FN_READ:    cmd.op = OP_RD_ISSUE;
          FN_REVERSE: cmd.op = OP_REV_INIT;
          FN_SORTED:  cmd.op = OP_SCAN_INIT;
          default:    cmd.op = OP_NONE;
        endcase
      end
      S_SCAN:   cmd.op = OP_SCAN;
      S_UP:     cmd.op = OP_UP;
      S_PLACE:  cmd.op = OP_PLACE;
      S_GRAB:   cmd.op = OP_GRAB;
      S_DOWN:   cmd.op = OP_DOWN;
      S_SHRINK: cmd.op = OP_DEC;
      S_REV_RD: if (stat.rev_more) cmd.op = OP_REV_RD;
      S_REV_W1: cmd.op = OP_REV_W1;
      S_REV_W2: cmd.op = OP_REV_W2;
      S_FINISH: if (out_free) cmd.op = OP_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

  assign out_valid_next = (state == S_FINISH && out_free) ? 1'b1 : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

// File: sv/pale_dp.sv
// Datapath of the positional array list engine: element memory, length,
// walk pointers and the response register. Depends on pale_pkg; commanded by pale_ctrl.
`default_nettype none

module pale_dp #(
  parameter int unsigned CAPACITY  = pale_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = pale_pkg::WORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [pale_pkg::FUNC_BITS-1:0]      in_func,
  input  wire logic [pale_pkg::POS_BITS-1:0]       in_position,
  input  wire logic signed [pale_pkg::ITEM_BITS-1:0] in_item_value,
  input  wire pale_pkg::cmd_t                      cmd,
  output pale_pkg::stat_t                          stat,
  output logic [pale_pkg::STATUS_BITS-1:0]         out_status,
  output logic signed [pale_pkg::ITEM_BITS-1:0]    out_read_value,
  output logic [pale_pkg::COUNT_BITS-1:0]          out_count_after
);
  import pale_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((LW > POS_BITS) ? LW : POS_BITS) + 1;

  logic signed [WORD_BITS-1:0] mem [CAPACITY];

  logic [LW-1:0]               len;
  logic [FUNC_BITS-1:0]        func_r;
  logic [POS_BITS-1:0]         pos_r;
  logic signed [WORD_BITS-1:0] val_r;
  logic signed [WORD_BITS-1:0] rv;
  logic signed [WORD_BITS-1:0] rd_a, rd_b;
  logic [AW-1:0]               k;
  logic [AW-1:0]               hi;
  logic [AW-1:0]               wr_addr;
  logic [LW-1:0]               ptr;
  logic                        pend;
  logic                        chk;

  logic [PW-1:0]               pos_w, len_w;
  logic [AW-1:0]               pos_idx, ptr_a;
  logic                        scan_hit;

  logic                        we, rea, reb;
  logic [AW-1:0]               waddr, ra, rb;
  logic signed [WORD_BITS-1:0] wdata;

  assign pos_w   = PW'(pos_r);
  assign len_w   = PW'(len);
  assign pos_idx = AW'(pos_w - PW'(1));
  assign ptr_a   = AW'(ptr);
  assign scan_hit = chk && (rd_a > val_r);

  always_comb begin
    stat.func        = func_r;
    stat.ins_pos_bad = (pos_w == '0) || (pos_w > len_w + PW'(1));
    stat.acc_pos_bad = (pos_w == '0) || (pos_w > len_w);
    stat.full        = (len == LW'(CAPACITY));
    stat.len_le1     = (len <= LW'(1));
    stat.scan_end    = scan_hit || (ptr == len);
    stat.up_more     = (ptr > LW'(k));
    stat.down_more   = ((LW + 1)'(ptr) + (LW + 1)'(1)) < (LW + 1)'(len);
    stat.rev_more    = (LW'(hi) > ptr);
  end

  // Memory port control: one write, two registered reads.
  always_comb begin
    we    = 1'b0;
    waddr = wr_addr;
    wdata = rd_a;
    rea   = 1'b0;
    ra    = ptr_a;
    reb   = 1'b0;
    rb    = hi;
    case (cmd.op)
      OP_SCAN: rea = !stat.scan_end;
      OP_UP: begin
        we = pend;
        if (stat.up_more) begin
          rea = 1'b1;
          ra  = AW'(ptr - LW'(1));
        end
      end
      OP_PLACE: begin
        we    = 1'b1;
        waddr = k;
        wdata = val_r;
      end
      OP_RD_ISSUE: begin
        rea = 1'b1;
        ra  = pos_idx;
      end
      OP_DOWN: begin
        we = pend;
        if (stat.down_more) begin
          rea = 1'b1;
          ra  = AW'(ptr + LW'(1));
        end
      end
      OP_REV_RD: begin
        rea = 1'b1;
        reb = 1'b1;
      end
      OP_REV_W1: begin
        we    = 1'b1;
        waddr = ptr_a;
        wdata = rd_b;
      end
      OP_REV_W2: begin
        we    = 1'b1;
        waddr = hi;
        wdata = rd_a;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rea) rd_a <= mem[ra];
    if (reb) rd_b <= mem[rb];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      pend <= 1'b0;
      chk  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_POS_INIT:  pend <= 1'b0;
        OP_SCAN_INIT: chk  <= 1'b0;
        OP_SCAN: begin
          if (stat.scan_end) pend <= 1'b0;
          else chk <= 1'b1;
        end
        OP_UP:       pend <= stat.up_more;
        OP_RD_ISSUE: pend <= 1'b0;
        OP_DOWN:     pend <= stat.down_more;
        OP_PLACE:    len  <= len + LW'(1);
        OP_DEC:      len  <= len - LW'(1);
        default:     pend <= pend;
      endcase
    end
  end

  // Payload, walk pointers and the response register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func_r <= in_func;
        pos_r  <= in_position;
        val_r  <= WORD_BITS'(in_item_value);
        rv     <= '0;
      end
      OP_POS_INIT: begin
        k   <= pos_idx;
        ptr <= len;
      end
      OP_SCAN_INIT: ptr <= '0;
      OP_SCAN: begin
        if (stat.scan_end) begin
          k   <= scan_hit ? AW'(ptr - LW'(1)) : ptr_a;
          ptr <= len;
        end else begin
          ptr <= ptr + LW'(1);
        end
      end
      OP_UP: begin
        if (stat.up_more) begin
          wr_addr <= ptr_a;
          ptr     <= ptr - LW'(1);
        end
      end
      OP_RD_ISSUE: ptr <= LW'(pos_idx);
      OP_GRAB:     rv  <= rd_a;
      OP_DOWN: begin
        if (stat.down_more) begin
          wr_addr <= ptr_a;
          ptr     <= ptr + LW'(1);
        end
      end
      OP_REV_INIT: begin
        ptr <= '0;
        hi  <= AW'(len - LW'(1));
      end
      OP_REV_W2: begin
        ptr <= ptr + LW'(1);
        hi  <= hi - AW'(1);
      end
      OP_FINISH: begin
        out_status      <= cmd.res;
        out_read_value  <= ITEM_BITS'(rv);
        out_count_after <= COUNT_BITS'(len);
      end
      default: rv <= rv;
    endcase
  end

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PLACE |-> len < LW'(CAPACITY))
    else $error("place issued on a full list");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DEC |-> len != '0)
    else $error("length decrement on an empty list");

  a_rev_order: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_REV_W2 |-> ptr < LW'(hi))
    else $error("reverse swap with crossed pointers");

  a_grab_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_GRAB |-> $past(cmd.op) == OP_RD_ISSUE)
    else $error("read data captured without a preceding read");

endmodule

`default_nettype wire

// File: sv/positional_array_list_engine.sv
// Top level of the positional array list engine: request and response channels,
// controller and datapath. Depends on pale_pkg, pale_ifs, pale_ctrl and pale_dp.
//
// The engine keeps an ordered list of up to CAPACITY signed WORD_BITS-bit words
// in a single memory with one write port and two registered read ports. Each
// request carries func, position and item_value and yields exactly one response
// with status, read_value and count_after. One request is worked at a time; a
// new request is taken once the previous one has finished, even while its
// response still waits in the output register. Steps per request: a read
// issues a memory read and grabs the word; a delete grabs it, shifts the tail
// down and shrinks the length; a positional insert shifts the tail up and places
// the word; a sorted insert first scans forward to the first larger word, then
// shifts the tail and places; a reverse swaps the end words pairwise, inward;
// failed or unused requests go straight to finish. The finish state holds while
// the previous response still waits in the output register, and the next request
// is accepted in the idle state that follows.
// Shifts move one word per cycle through the memory's write port, and a reverse
// swap reads both words at once and writes them back one at a time through that
// same port. Positions out of range return status 1, growth of a full list
// returns status 2, and read_value is zero except for a successful read or
// delete. No clearing pass follows reset: only the length is cleared, and no
// word beyond the length is ever read.
`default_nettype none

module positional_array_list_engine #(
  parameter int unsigned CAPACITY  = pale_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = pale_pkg::WORD_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pale_req_if.sink   req,
  pale_rsp_if.source rsp
);
  import pale_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request: decode, walk the memory, register the response.
  pale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold the list, its length and the response payload.
  pale_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_func         (req.func),
    .in_position     (req.position),
    .in_item_value   (req.item_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (rsp.status),
    .out_read_value  (rsp.read_value),
    .out_count_after (rsp.count_after)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for positional_array_list_engine: directed and random
// requests, a list predictor inside a small scoreboard class, random stalls on
// both channels. Depends on pale_pkg, pale_ifs and the engine RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pale_pkg::*;

  localparam int unsigned LIST_CAP       = CAPACITY_DEF;
  localparam int unsigned REQUEST_TARGET = 500;
  // Worst request: a full-list shift or reverse in the engine, the longest sender
  // gap and receiver stall. Take that over every request and several times over.
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  // One predicted response.
  typedef struct {
    status_t                     status;
    logic signed [ITEM_BITS-1:0] word;
    logic [COUNT_BITS-1:0]       count;
  } list_result_t;

  // Scoreboard: mirrors the list contents and length, queues the response
  // every accepted request should produce, and checks responses in order.
  class list_scoreboard;
    logic signed [ITEM_BITS-1:0] words [LIST_CAP];
    int unsigned                 length;
    list_result_t                awaited[$];
    int unsigned                 errors;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Open a slot at index k by moving the tail up one place, store the value there and grow the length.
    function void place(int unsigned k, logic signed [ITEM_BITS-1:0] value);
      int unsigned j;
      for (j = length; j > k; j--) words[j] = words[j-1];
      words[k] = value;
      length++;
    endfunction

    function void note_request(logic [FUNC_BITS-1:0] func, logic [POS_BITS-1:0] pos,
                               logic signed [ITEM_BITS-1:0] value);
      list_result_t                r;
      int unsigned                 k;
      logic signed [ITEM_BITS-1:0] held;
      r.status = ST_OK;
      r.word   = '0;
      case (func)
        FN_INSERT: begin
          if (pos == 0 || pos > length + 1) r.status = ST_BAD_POS;
          else if (length >= LIST_CAP) r.status = ST_FULL;
          else place(pos - 1, value);
        end
        FN_DELETE: begin
          if (pos == 0 || pos > length) begin
            r.status = ST_BAD_POS;
          end else begin
            r.word = words[pos-1];
            for (k = pos - 1; k + 1 < length; k++) words[k] = words[k+1];
            length--;
          end
        end
        FN_REVERSE: begin
          for (k = 0; k < length / 2; k++) begin
            held                 = words[k];
            words[k]             = words[length-1-k];
            words[length-1-k]    = held;
          end
        end
        FN_SORTED: begin
          if (length >= LIST_CAP) begin
            r.status = ST_FULL;
          end else begin
            // Land before the first word that is greater than the new one.
            k = 0;
            while (k < length && words[k] <= value) k++;
            place(k, value);
          end
        end
        FN_READ: begin
          if (pos == 0 || pos > length) r.status = ST_BAD_POS;
          else r.word = words[pos-1];
        end
        default: ;
      endcase
      r.count = length[COUNT_BITS-1:0];
      awaited.push_back(r);
    endfunction

    task check_response(logic [STATUS_BITS-1:0] status, logic signed [ITEM_BITS-1:0] word,
                        logic [COUNT_BITS-1:0] count);
      list_result_t e;
      if (awaited.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, predicted %0d", status, e.status));
      if (word !== e.word)
        report($sformatf("read_value %0d, predicted %0d", word, e.word));
      if (count !== e.count)
        report($sformatf("count_after %0d, predicted %0d", count, e.count));
    endtask
  endclass

  logic clk;
  logic rst;
  int unsigned cycle_count = 0;
  bit send_burst = 1'b0;
  list_scoreboard sb = new();

  pale_req_if req_ch ();
  pale_rsp_if rsp_ch ();

  positional_array_list_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until accepted. Valid
  // stays high on return so a back-to-back request does not drop valid in between.
  task automatic send_request(input logic [FUNC_BITS-1:0] func, input logic [POS_BITS-1:0] pos,
                              input logic signed [ITEM_BITS-1:0] value);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.position   <= pos;
    req_ch.item_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(func, pos, value);
  endtask

  // Drop valid and hold off until every predicted response has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // Mostly full-range words, with a cluster of small values to force equal
  // keys in sorted inserts, and the two extremes.
  function automatic logic signed [ITEM_BITS-1:0] pick_value();
    logic signed [ITEM_BITS-1:0] v;
    case ($urandom_range(0, 9))
      6, 7: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      8: v = 32'sh7FFF_FFFF;
      9: v = 32'sh8000_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic run_directed();
    send_request(FN_READ, 8'd1, '0);                 // read from empty list
    send_request(FN_DELETE, 8'd1, '0);               // delete from empty list
    send_request(FN_REVERSE, 8'd0, '0);              // reverse empty list
    send_request(FN_INSERT, 8'd0, 32'sd9);           // position zero
    send_request(FN_INSERT, 8'd2, 32'sd9);           // past length+1
    send_request(FN_SORTED, 8'd0, 32'sd5);           // sorted insert into empty list
    send_request(FN_REVERSE, 8'd0, '0);              // reverse one word
    send_request(FN_SORTED, 8'd0, 32'sd5);           // equal to last word
    send_request(FN_INSERT, 8'd1, 32'sh7FFF_FFFF);   // head, largest word
    send_request(FN_INSERT, 8'd4, 32'sh8000_0000);   // tail, smallest word
    send_request(FN_INSERT, 8'd255, 32'sd1);         // far out of range
    send_request(FN_SORTED, 8'd0, -32'sd1);
    send_request(FN_READ, 8'd255, '0);
    send_request(FN_READ, 8'd0, '0);
    send_request(FN_REVERSE, 8'd0, '0);
    send_request(FN_READ, 8'd1, '0);
    send_request(FN_READ, 8'd5, '0);
    send_request(FN_DELETE, 8'd0, '0);
    send_request(FN_DELETE, 8'd6, '0);               // one past the end
    send_request(FN_DELETE, 8'd5, '0);               // last word
    send_request(FN_DELETE, 8'd1, '0);               // first word
    send_request(3'd5, 8'hAA, 32'sh5555_5555);       // unused codes
    send_request(3'd6, 8'h55, 32'shAAAA_AAAA);
    send_request(3'd7, 8'hFF, '1);
    send_request(FN_INSERT, 8'd2, '0);
    wait_drained();
  endtask

  // Alternate growing and shrinking phases so the list runs between empty and
  // full; probe the full list before turning around.
  task automatic run_random();
    int unsigned issued;
    int unsigned len;
    int unsigned r;
    bit shrinking;
    logic [FUNC_BITS-1:0] f;
    issued    = 0;
    shrinking = 1'b0;
    while (issued < REQUEST_TARGET) begin
      len = sb.length;
      if (!shrinking && len == LIST_CAP) begin
        send_request(FN_INSERT, POS_BITS'($urandom_range(1, LIST_CAP + 1)), pick_value());
        send_request(FN_SORTED, POS_BITS'($urandom_range(0, 255)), pick_value());
        send_request(FN_INSERT, POS_BITS'(LIST_CAP + 2), pick_value());
        issued += 3;
        shrinking = 1'b1;
        wait_drained();
        continue;
      end
      if (shrinking && len == 0) begin
        shrinking = 1'b0;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Noise: any code, any position.
        f = FUNC_BITS'($urandom_range(0, 7));
        send_request(f, POS_BITS'($urandom_range(0, 255)), pick_value());
        if (f <= FN_READ) issued++;
        continue;
      end
      if (shrinking) r = (r < 15) ? 10 : (r < 20) ? 50 : (r < 70) ? 80 : (r < 85) ? 85 : 95;
      if (r < 50)
        send_request(FN_INSERT, POS_BITS'($urandom_range(1, len + 1)), pick_value());
      else if (r < 80)
        send_request(FN_SORTED, POS_BITS'($urandom_range(0, 255)), pick_value());
      else if (r < 85)
        send_request(FN_DELETE, POS_BITS'((len == 0) ? 1 : $urandom_range(1, len)), '0);
      else if (r < 95)
        send_request(FN_READ, POS_BITS'((len == 0) ? 1 : $urandom_range(1, len)),
                     $urandom());
      else
        send_request(FN_REVERSE, POS_BITS'($urandom_range(0, 255)), $urandom());
      issued++;
    end
  endtask

  // Response side: stall ready at random, check every accepted response.
  initial begin : response_sink
    int unsigned stall;
    bit burst;
    burst = 1'b0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_response(rsp_ch.status, rsp_ch.read_value, rsp_ch.count_after);
    end
  end

  // Main sequence: reset once, directed requests, random requests, drain.
  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= '0;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    wait_drained();
    // Let any stray response surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/pale_pkg.sv
sv/pale_ifs.sv
sv/pale_ctrl.sv
sv/pale_dp.sv
sv/positional_array_list_engine.sv
tb/tb.sv
